>>> hw/rtl/two_pass_chamfer_distance_unit_macros.svh
// assertion macros for the two-pass chamfer distance unit
// no dependencies; the assertions compile out when SYNTH is defined
`ifndef TWO_PASS_CHAMFER_DISTANCE_UNIT_MACROS_SVH
`define TWO_PASS_CHAMFER_DISTANCE_UNIT_MACROS_SVH

`ifndef SYNTH

`define TPCD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpcd: same-cycle check failed");

`define TPCD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpcd: next-cycle check failed");

`else

`define TPCD_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define TPCD_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/tpcd_pkg.sv
// shared types, sizes and helper functions of the chamfer distance unit
// no dependencies
package tpcd_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int DIST_BITS  = 9;
    localparam int DIM_BITS   = 9;
    localparam int MEM_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS  = $clog2(MEM_DEPTH);
    localparam int POS_BITS   = ADDR_BITS + 1;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
    localparam logic [DIM_BITS-1:0]  DIM_MIN  = DIM_BITS'(3);
    localparam logic [DIM_BITS-1:0]  WIDTH_HI = DIM_BITS'(MAX_WIDTH);
    localparam logic [DIM_BITS-1:0]  HEIGHT_HI = DIM_BITS'(MAX_HEIGHT);

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_EIGHT  = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic action;
        logic pixel;
    } t_in;

    typedef struct packed {
        logic [DIST_BITS-1:0] distance;
        logic                 last;
    } t_out;

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                      input logic [DIM_BITS-1:0] hi);
        logic [DIM_BITS-1:0] res;
        if (v < DIM_MIN) begin
            res = DIM_MIN;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic [POS_BITS-1:0] frame_total(input logic [DIM_BITS-1:0] w,
                                                        input logic [DIM_BITS-1:0] h);
        logic [2*DIM_BITS-1:0] prod;
        prod = {{DIM_BITS{1'b0}}, w} * {{DIM_BITS{1'b0}}, h};
        return prod[POS_BITS-1:0];
    endfunction

    function automatic logic [DIST_BITS-1:0] inc_sat(input logic [DIST_BITS-1:0] v);
        logic [DIST_BITS-1:0] res;
        if (v == DIST_MAX) begin
            res = DIST_MAX;
        end else begin
            res = v + DIST_BITS'(1);
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/tpcd_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module tpcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/two_pass_chamfer_distance_unit.sv
// two-pass chamfer distance unit: loads a mask, runs forward and backward passes, reads back
// uses tpcd_pkg, tpcd_ram and two_pass_chamfer_distance_unit_macros.svh
// load: one pixel per cycle; read: distance on o_strobe one cycle after the beat, one per cycle
// after the last pixel, busy for both passes over the interior through the single ram port:
// 4 cycles per foreground pixel per pass (6 with eight_connected), 2 per background pixel
// reset (synchronous, active low) clears control and config; ram contents are not cleared
`include "two_pass_chamfer_distance_unit_macros.svh"

module two_pass_chamfer_distance_unit
    import tpcd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  t_in                     i_item,
    output logic                    o_strobe,
    output t_out                    o_result,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [DIM_BITS-1:0]     i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_FWD  = 3'b010,
        S_BWD  = 3'b100
    } t_state;

    localparam logic [2:0] STEP_CTR   = 3'd0;
    localparam logic [2:0] STEP_HOR   = 3'd1;
    localparam logic [2:0] STEP_VER   = 3'd2;
    localparam logic [2:0] STEP_VL    = 3'd3;
    localparam logic [2:0] STEP_LAST4 = 3'd3;
    localparam logic [2:0] STEP_LAST8 = 3'd5;

    t_state                r_state, n_state;
    logic [2:0]            r_step, n_step;
    logic                  r_eight, n_eight;
    logic [DIM_BITS-1:0]   r_w, n_w;
    logic [DIM_BITS-1:0]   r_h, n_h;
    logic [POS_BITS-1:0]   r_total, n_total;
    logic [POS_BITS-1:0]   r_load_pos, n_load_pos;
    logic [POS_BITS-1:0]   r_read_pos, n_read_pos;
    logic                  r_ready, n_ready;
    logic                  r_out_v, n_out_v;
    logic                  r_out_last, n_out_last;
    logic [DIM_BITS-1:0]   r_row, n_row;
    logic [DIM_BITS-1:0]   r_col, n_col;
    logic [ADDR_BITS-1:0]  r_p, n_p;
    logic [DIST_BITS-1:0]  r_cur, n_cur;
    logic [DIST_BITS-1:0]  r_acc, n_acc;

    logic                  accept;
    logic                  rd_issue;
    logic                  fwd;
    logic [2:0]            last_step;
    logic [ADDR_BITS-1:0]  w_ext;
    logic [ADDR_BITS-1:0]  vert;
    logic [ADDR_BITS-1:0]  horiz;
    logic [ADDR_BITS-1:0]  pass_addr;
    logic [DIM_BITS-1:0]   w_m2;
    logic [DIM_BITS-1:0]   h_m2;
    logic [POS_BITS-1:0]   ld_pos;
    logic [DIST_BITS-1:0]  rdata;
    logic [DIST_BITS-1:0]  min_v;
    logic [DIST_BITS-1:0]  m_inc;
    logic                  pixel_done;
    logic                  ram_we;
    logic [ADDR_BITS-1:0]  ram_waddr;
    logic [DIST_BITS-1:0]  ram_wdata;
    logic                  ram_re;
    logic [ADDR_BITS-1:0]  ram_raddr;
    logic [DIM_BITS-1:0]   cfg_dim;

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign rd_issue  = accept && (i_item.action == ACT_READ) && r_ready;
    assign fwd       = (r_state == S_FWD);
    assign last_step = r_eight ? STEP_LAST8 : STEP_LAST4;
    assign w_ext     = {{(ADDR_BITS-DIM_BITS){1'b0}}, r_w};
    assign w_m2      = r_w - DIM_BITS'(2);
    assign h_m2      = r_h - DIM_BITS'(2);
    assign vert      = fwd ? (r_p - w_ext) : (r_p + w_ext);
    assign horiz     = fwd ? (r_p - ADDR_BITS'(1)) : (r_p + ADDR_BITS'(1));
    assign ld_pos    = r_ready ? '0 : r_load_pos;
    assign cfg_dim   = i_cfg_data;

    always_comb begin
        case (r_step)
            STEP_CTR: pass_addr = r_p;
            STEP_HOR: pass_addr = horiz;
            STEP_VER: pass_addr = vert;
            STEP_VL:  pass_addr = vert - ADDR_BITS'(1);
            default:  pass_addr = vert + ADDR_BITS'(1);
        endcase
    end

    // running minimum over the neighbors, then saturating increment
    assign min_v      = (r_step == STEP_VER) ? rdata : ((rdata < r_acc) ? rdata : r_acc);
    assign m_inc      = inc_sat(min_v);
    assign pixel_done = busy && (((r_step == STEP_HOR) && (rdata == '0))
                                 || (r_step == last_step));

    assign ram_re    = busy || rd_issue;
    assign ram_raddr = busy ? pass_addr : r_read_pos[ADDR_BITS-1:0];

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = ld_pos[ADDR_BITS-1:0];
        ram_wdata = {{(DIST_BITS-1){1'b0}}, i_item.pixel};
        if (busy) begin
            ram_waddr = r_p;
            ram_wdata = m_inc;
            ram_we    = (r_step == last_step) && (fwd || (r_cur > m_inc));
        end else if (accept && (i_item.action == ACT_LOAD)) begin
            ram_we = 1'b1;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_eight    = r_eight;
        n_w        = r_w;
        n_h        = r_h;
        n_total    = r_total;
        n_load_pos = r_load_pos;
        n_read_pos = r_read_pos;
        n_ready    = r_ready;
        n_out_v    = rd_issue;
        n_out_last = r_out_last;
        n_row      = r_row;
        n_col      = r_col;
        n_p        = r_p;
        n_cur      = r_cur;
        n_acc      = r_acc;

        if (accept && (i_item.action == ACT_LOAD)) begin
            if (r_ready) begin
                n_ready    = 1'b0;
                n_read_pos = '0;
            end
            if ((ld_pos + POS_BITS'(1)) == r_total) begin
                n_load_pos = '0;
                n_read_pos = '0;
                n_state    = S_FWD;
                n_step     = STEP_CTR;
                n_row      = DIM_BITS'(1);
                n_col      = DIM_BITS'(1);
                n_p        = w_ext + ADDR_BITS'(1);
            end else begin
                n_load_pos = ld_pos + POS_BITS'(1);
            end
        end

        if (rd_issue) begin
            if ((r_read_pos + POS_BITS'(1)) == r_total) begin
                n_out_last = 1'b1;
                n_ready    = 1'b0;
                n_read_pos = '0;
                n_load_pos = '0;
            end else begin
                n_out_last = 1'b0;
                n_read_pos = r_read_pos + POS_BITS'(1);
            end
        end

        if (busy) begin
            n_step = r_step + 3'd1;
            if (r_step == STEP_HOR) begin
                n_cur = rdata;
            end
            if (r_step >= STEP_VER) begin
                n_acc = min_v;
            end
            if (pixel_done) begin
                n_step = STEP_CTR;
                if (fwd) begin
                    if ((r_row == h_m2) && (r_col == w_m2)) begin
                        n_state = S_BWD;
                        n_row   = h_m2;
                        n_col   = w_m2;
                        n_p     = r_total[ADDR_BITS-1:0] - w_ext - ADDR_BITS'(2);
                    end else if (r_col == w_m2) begin
                        n_col = DIM_BITS'(1);
                        n_row = r_row + DIM_BITS'(1);
                        n_p   = r_p + ADDR_BITS'(3);
                    end else begin
                        n_col = r_col + DIM_BITS'(1);
                        n_p   = r_p + ADDR_BITS'(1);
                    end
                end else begin
                    if ((r_row == DIM_BITS'(1)) && (r_col == DIM_BITS'(1))) begin
                        n_state    = S_IDLE;
                        n_ready    = 1'b1;
                        n_read_pos = '0;
                        n_load_pos = '0;
                    end else if (r_col == DIM_BITS'(1)) begin
                        n_col = w_m2;
                        n_row = r_row - DIM_BITS'(1);
                        n_p   = r_p - ADDR_BITS'(3);
                    end else begin
                        n_col = r_col - DIM_BITS'(1);
                        n_p   = r_p - ADDR_BITS'(1);
                    end
                end
            end
        end

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EIGHT: begin
                    n_eight = i_cfg_data[0];
                end
                CFG_WIDTH: begin
                    n_w     = clamp_dim(cfg_dim, WIDTH_HI);
                    n_total = frame_total(clamp_dim(cfg_dim, WIDTH_HI), r_h);
                end
                CFG_HEIGHT: begin
                    n_h     = clamp_dim(cfg_dim, HEIGHT_HI);
                    n_total = frame_total(r_w, clamp_dim(cfg_dim, HEIGHT_HI));
                end
                default: begin
                    n_eight = r_eight;
                end
            endcase
            if ((i_cfg_idx == CFG_EIGHT) || (i_cfg_idx == CFG_WIDTH)
                    || (i_cfg_idx == CFG_HEIGHT)) begin
                n_load_pos = '0;
                n_read_pos = '0;
                n_ready    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= STEP_CTR;
            r_eight    <= 1'b0;
            r_w        <= WIDTH_HI;
            r_h        <= HEIGHT_HI;
            r_total    <= frame_total(WIDTH_HI, HEIGHT_HI);
            r_load_pos <= '0;
            r_read_pos <= '0;
            r_ready    <= 1'b0;
            r_out_v    <= 1'b0;
            r_row      <= DIM_BITS'(1);
            r_col      <= DIM_BITS'(1);
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_eight    <= n_eight;
            r_w        <= n_w;
            r_h        <= n_h;
            r_total    <= n_total;
            r_load_pos <= n_load_pos;
            r_read_pos <= n_read_pos;
            r_ready    <= n_ready;
            r_out_v    <= n_out_v;
            r_row      <= n_row;
            r_col      <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_last <= n_out_last;
        r_p        <= n_p;
        r_cur      <= n_cur;
        r_acc      <= n_acc;
    end

    tpcd_ram #(
        .WIDTH (DIST_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    assign o_strobe          = r_out_v;
    assign o_result.distance = rdata;
    assign o_result.last     = r_out_last;

    `TPCD_ASSERT_NXT(a_read_gives_beat, i_clk, i_rst_n, rd_issue, o_strobe)
    `TPCD_ASSERT_IMP(a_beat_from_read, i_clk, i_rst_n, o_strobe, $past(rd_issue))
    `TPCD_ASSERT_IMP(a_no_ready_in_pass, i_clk, i_rst_n, busy, !r_ready)
    `TPCD_ASSERT_IMP(a_pass_in_frame, i_clk, i_rst_n, busy, POS_BITS'(r_p) < r_total)
    `TPCD_ASSERT_IMP(a_step_bound, i_clk, i_rst_n, busy, r_step <= last_step)

endmodule
